FILE: hdl/shlc_pkg.sv
`timescale 1ns / 1ps
// shlc_pkg: types, character codes and helper functions for the greeting line checker
// no dependencies; used by shlc_line_fsm and the top module of the checker

package shlc_pkg;

  // character codes
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_DOT   = 8'd46;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;
  localparam logic [7:0] CH_OPEN  = 8'd91;
  localparam logic [7:0] CH_CLOSE = 8'd93;
  localparam logic [7:0] CH_LOW_A = 8'd97;
  localparam logic [7:0] CH_LOW_Z = 8'd122;
  localparam logic [7:0] CASE_OFS = 8'd32;

  // command word lengths and address literal bounds
  localparam logic [2:0] CMD_LEN_WORD = 3'd4;
  localparam logic [2:0] CMD_LEN_MAX  = 3'd5;
  localparam logic [1:0] DOTS_NEEDED  = 2'd3;
  localparam logic [1:0] OCTET_MAX    = 2'd3;

  typedef enum logic [2:0] {
    PH_CMD       = 3'd0,
    PH_ARG_FIRST = 3'd1,
    PH_ARG       = 3'd2,
    PH_TRAIL     = 3'd3
  } phase_t;

  typedef enum logic [1:0] {
    LIT_NONE   = 2'd0,
    LIT_OPEN   = 2'd1,
    LIT_CLOSED = 2'd2
  } lit_mode_t;

  typedef enum logic [1:0] {
    V_OK      = 2'd0,
    V_SYNTAX  = 2'd1,
    V_LITERAL = 2'd2
  } verdict_t;

  typedef enum logic [1:0] {
    K_UNKNOWN = 2'd0,
    K_HELO    = 2'd1,
    K_EHLO    = 2'd2
  } kind_t;

  // per-line state
  typedef struct packed {
    phase_t     phase;
    logic [2:0] cmd_len;
    logic       helo_ok;
    logic       ehlo_ok;
    logic       syntax_bad;
    lit_mode_t  lit_mode;
    logic [1:0] digit_cnt;
    logic [1:0] dot_cnt;
    logic       lit_bad;
  } line_state_t;

  // verdict for one line, from the parser to the output register
  typedef struct packed {
    logic     valid;
    verdict_t verdict;
    kind_t    kind;
  } line_result_t;

  localparam line_state_t LINE_CLEAR = '{
    phase:      PH_CMD,
    cmd_len:    3'd0,
    helo_ok:    1'b1,
    ehlo_ok:    1'b1,
    syntax_bad: 1'b0,
    lit_mode:   LIT_NONE,
    digit_cnt:  2'd0,
    dot_cnt:    2'd0,
    lit_bad:    1'b0
  };

  // fold a-z to upper case
  function automatic logic [7:0] upper_case(input logic [7:0] c);
    if (c >= CH_LOW_A && c <= CH_LOW_Z) begin
      return c - CASE_OFS;
    end
    return c;
  endfunction

  // letters of HELO
  function automatic logic [7:0] helo_char(input logic [1:0] idx);
    logic [7:0] ch;
    unique case (idx)
      2'd0:    ch = 8'h48;
      2'd1:    ch = 8'h45;
      2'd2:    ch = 8'h4C;
      default: ch = 8'h4F;
    endcase
    return ch;
  endfunction

  // letters of EHLO
  function automatic logic [7:0] ehlo_char(input logic [1:0] idx);
    logic [7:0] ch;
    unique case (idx)
      2'd0:    ch = 8'h45;
      2'd1:    ch = 8'h48;
      2'd2:    ch = 8'h4C;
      default: ch = 8'h4F;
    endcase
    return ch;
  endfunction

endpackage

FILE: hdl/shlc_in_stage.sv
`timescale 1ns / 1ps
// shlc_in_stage: input register for one line character
// depends on nothing but the clock and reset

module shlc_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_in,
  input  logic       consume,
  output logic       hold_valid,
  output logic [7:0] hold_char
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] char_r;
  logic       load;

  // stall only while a held request cannot move on
  assign in_stall = valid_r && !consume;
  assign load     = !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = in_valid;
    end
  end

  // control register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload register
  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      char_r <= in_char_in;
    end
  end

  assign hold_valid = valid_r;
  assign hold_char  = char_r;

endmodule

FILE: hdl/shlc_line_fsm.sv
`timescale 1ns / 1ps
// shlc_line_fsm: line state registers and the per-character next-state logic
// depends on shlc_pkg

module shlc_line_fsm (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  logic [7:0]            char_in,
  output shlc_pkg::line_result_t result
);

  shlc_pkg::line_state_t state_r;
  shlc_pkg::line_state_t state_nxt;
  logic                  after_cr_r;
  logic                  after_cr_nxt;

  logic       blank;
  logic       is_digit;
  logic       is_helo;
  logic       is_ehlo;
  logic       end_sb;
  logic       end_lb;
  logic [7:0] up_char;

  assign blank    = (char_in == shlc_pkg::CH_SPACE) || (char_in == shlc_pkg::CH_TAB);
  assign is_digit = (char_in >= shlc_pkg::CH_ZERO) && (char_in <= shlc_pkg::CH_NINE);
  assign up_char  = shlc_pkg::upper_case(char_in);

  // line end verdict terms
  assign end_sb  = state_r.syntax_bad || (state_r.phase == shlc_pkg::PH_CMD) ||
                   (state_r.phase == shlc_pkg::PH_ARG_FIRST);
  assign end_lb  = state_r.lit_bad ||
                   ((state_r.phase == shlc_pkg::PH_ARG) &&
                    (state_r.lit_mode == shlc_pkg::LIT_OPEN));
  assign is_helo = (state_r.cmd_len == shlc_pkg::CMD_LEN_WORD) && state_r.helo_ok;
  assign is_ehlo = (state_r.cmd_len == shlc_pkg::CMD_LEN_WORD) && state_r.ehlo_ok;

  // next state and result
  always_comb begin
    state_nxt      = state_r;
    after_cr_nxt   = after_cr_r;
    result.valid   = 1'b0;
    result.verdict = shlc_pkg::V_OK;
    result.kind    = shlc_pkg::K_UNKNOWN;

    if (is_helo) begin
      result.kind = shlc_pkg::K_HELO;
    end else if (is_ehlo) begin
      result.kind = shlc_pkg::K_EHLO;
    end

    if (end_sb) begin
      result.verdict = shlc_pkg::V_SYNTAX;
    end else if (is_helo) begin
      result.verdict = end_lb ? shlc_pkg::V_LITERAL : shlc_pkg::V_OK;
    end else if (is_ehlo) begin
      result.verdict = shlc_pkg::V_OK;
    end else begin
      result.verdict = shlc_pkg::V_SYNTAX;
    end

    priority if (char_in == shlc_pkg::CH_LF && after_cr_r) begin
      // second half of a CR LF pair
      after_cr_nxt = 1'b0;
    end else if (char_in == shlc_pkg::CH_CR || char_in == shlc_pkg::CH_LF) begin
      // line end: give the verdict and start over
      result.valid = 1'b1;
      state_nxt    = shlc_pkg::LINE_CLEAR;
      after_cr_nxt = (char_in == shlc_pkg::CH_CR);
    end else begin
      after_cr_nxt = 1'b0;
      unique case (state_r.phase)
        shlc_pkg::PH_CMD: begin
          if (char_in == shlc_pkg::CH_SPACE) begin
            if (state_r.cmd_len == 3'd0) begin
              state_nxt.syntax_bad = 1'b1;
            end
            state_nxt.phase = shlc_pkg::PH_ARG_FIRST;
          end else if (char_in == shlc_pkg::CH_TAB) begin
            state_nxt.syntax_bad = 1'b1;
          end else begin
            if (state_r.cmd_len < shlc_pkg::CMD_LEN_WORD) begin
              if (up_char != shlc_pkg::helo_char(state_r.cmd_len[1:0])) begin
                state_nxt.helo_ok = 1'b0;
              end
              if (up_char != shlc_pkg::ehlo_char(state_r.cmd_len[1:0])) begin
                state_nxt.ehlo_ok = 1'b0;
              end
            end else begin
              state_nxt.helo_ok = 1'b0;
              state_nxt.ehlo_ok = 1'b0;
            end
            if (state_r.cmd_len < shlc_pkg::CMD_LEN_MAX) begin
              state_nxt.cmd_len = state_r.cmd_len + 3'd1;
            end
          end
        end
        shlc_pkg::PH_ARG_FIRST: begin
          if (blank) begin
            state_nxt.syntax_bad = 1'b1;
          end else begin
            if (char_in == shlc_pkg::CH_OPEN) begin
              state_nxt.lit_mode = shlc_pkg::LIT_OPEN;
            end
            state_nxt.phase = shlc_pkg::PH_ARG;
          end
        end
        shlc_pkg::PH_ARG: begin
          if (blank) begin
            if (state_r.lit_mode == shlc_pkg::LIT_OPEN) begin
              state_nxt.lit_bad = 1'b1;
            end
            state_nxt.phase = shlc_pkg::PH_TRAIL;
          end else if (state_r.lit_mode != shlc_pkg::LIT_NONE) begin
            // address literal checks
            priority if (state_r.lit_mode == shlc_pkg::LIT_CLOSED) begin
              state_nxt.lit_bad = 1'b1;
            end else if (is_digit) begin
              if (state_r.digit_cnt >= shlc_pkg::OCTET_MAX) begin
                state_nxt.lit_bad = 1'b1;
              end else begin
                state_nxt.digit_cnt = state_r.digit_cnt + 2'd1;
              end
            end else if (char_in == shlc_pkg::CH_DOT) begin
              if (state_r.digit_cnt == 2'd0 || state_r.dot_cnt >= shlc_pkg::DOTS_NEEDED) begin
                state_nxt.lit_bad = 1'b1;
              end else begin
                state_nxt.dot_cnt   = state_r.dot_cnt + 2'd1;
                state_nxt.digit_cnt = 2'd0;
              end
            end else if (char_in == shlc_pkg::CH_CLOSE) begin
              if (state_r.dot_cnt != shlc_pkg::DOTS_NEEDED || state_r.digit_cnt == 2'd0) begin
                state_nxt.lit_bad = 1'b1;
              end
              state_nxt.lit_mode = shlc_pkg::LIT_CLOSED;
            end else begin
              state_nxt.lit_bad = 1'b1;
            end
          end
        end
        default: begin
          if (!blank) begin
            state_nxt.syntax_bad = 1'b1;
          end
        end
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= shlc_pkg::LINE_CLEAR;
      after_cr_r <= 1'b0;
    end else if (step) begin
      state_r    <= state_nxt;
      after_cr_r <= after_cr_nxt;
    end
  end

  // a verdict always leaves a fresh line behind
  a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    step && result.valid |=> state_r.phase == shlc_pkg::PH_CMD && state_r.cmd_len == 3'd0)
    else $error("line state not cleared after line end");

  // command length saturates
  a_len_sat: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.cmd_len <= shlc_pkg::CMD_LEN_MAX)
    else $error("command length past saturation");

  // a literal only exists inside or after the argument
  a_lit_phase: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.lit_mode != shlc_pkg::LIT_NONE |->
      state_r.phase == shlc_pkg::PH_ARG || state_r.phase == shlc_pkg::PH_TRAIL)
    else $error("literal mode outside argument");

endmodule

FILE: hdl/smtp_helo_line_checker_top.sv
`timescale 1ns / 1ps
// smtp_helo_line_checker_top: greeting line checker, input register, parser, result register
// depends on shlc_pkg, shlc_in_stage and shlc_line_fsm
//
//   channel   direction   ports                                      request
//   in        input       in_valid, in_stall, in_char_in             one line character
//   out       output      out_valid, out_stall, out_verdict,         one verdict per line end
//                         out_command_kind
//
// one character per cycle while out_stall does not hold the result register; a verdict for a line end
// goes from the input register through the parser into the result register
// a LF right after CR, and any other non-ending character, give no request on out
// rst_n is synchronous and active low; it clears the line state and both valid flags
// out_stall holds the result register, and in_stall rises once a character waits behind it

module smtp_helo_line_checker_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_verdict,
  output logic [1:0] out_command_kind
);

  logic                   hold_valid;
  logic [7:0]             hold_char;
  logic                   can_load;
  logic                   step;
  shlc_pkg::line_result_t result;
  logic                   out_valid_r;
  logic                   out_valid_nxt;
  shlc_pkg::verdict_t     verdict_r;
  shlc_pkg::kind_t        kind_r;

  // result register free or draining this cycle
  assign can_load = !out_valid_r || !out_stall;
  assign step     = hold_valid && can_load;

  shlc_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_char_in (in_char_in),
    .consume    (can_load),
    .hold_valid (hold_valid),
    .hold_char  (hold_char)
  );

  shlc_line_fsm u_line_fsm (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .char_in (hold_char),
    .result  (result)
  );

  // result valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (can_load) begin
      out_valid_nxt = step && result.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (step && result.valid) begin
      verdict_r <= result.verdict;
      kind_r    <= result.kind;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_verdict      = verdict_r;
  assign out_command_kind = kind_r;

  // input stalls only behind a blocked result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r && out_stall)
    else $error("input stalled while result register free");

  // a bad literal only comes with HELO
  a_lit_helo: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && verdict_r == shlc_pkg::V_LITERAL |-> kind_r == shlc_pkg::K_HELO)
    else $error("literal verdict without HELO");

  // an accepted verdict names a known command
  a_ok_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && verdict_r == shlc_pkg::V_OK |-> kind_r != shlc_pkg::K_UNKNOWN)
    else $error("accepted line without known command");

endmodule

FILE: tb/tb_smtp_helo_line_checker_top.sv
`timescale 1ns / 1ps
// tb_smtp_helo_line_checker_top: self-checking bench for the greeting line checker
// depends on shlc_pkg and smtp_helo_line_checker_top; predicts one verdict per line end

module tb_smtp_helo_line_checker_top;

  localparam int unsigned ITEM_TARGET = 1750;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned REPORT_MAX  = 10;

  typedef struct {
    shlc_pkg::verdict_t verdict;
    shlc_pkg::kind_t    kind;
  } line_verdict_t;

  typedef enum int unsigned {RX_FREE, RX_HALF, RX_LIGHT, RX_HEAVY} stall_mode_t;

  typedef enum int unsigned {
    FLAW_NONE, FLAW_OCTETS, FLAW_DIGITS, FLAW_NO_CLOSE, FLAW_AFTER_CLOSE,
    FLAW_LETTER, FLAW_EXTRA_DOT
  } lit_flaw_t;

  // line predictor and store of pending verdicts
  class verdict_scoreboard;
    line_verdict_t       expected_q[$];
    int unsigned         failures;
    shlc_pkg::phase_t    phase;
    logic [2:0]          word_len;
    bit                  helo_hit, ehlo_hit, syntax_err, lit_err, saw_cr;
    shlc_pkg::lit_mode_t lit;
    logic [1:0]          digit_cnt, dot_cnt;
    string               helo_text = "HELO";
    string               ehlo_text = "EHLO";

    function new();
      failures = 0;
      saw_cr   = 1'b0;
      restart_line();
    endfunction

    function void restart_line();
      phase      = shlc_pkg::PH_CMD;
      word_len   = 3'd0;
      helo_hit   = 1'b1;
      ehlo_hit   = 1'b1;
      syntax_err = 1'b0;
      lit        = shlc_pkg::LIT_NONE;
      digit_cnt  = 2'd0;
      dot_cnt    = 2'd0;
      lit_err    = 1'b0;
    endfunction

    function void finish_argument();
      if (lit == shlc_pkg::LIT_OPEN) lit_err = 1'b1;
      phase = shlc_pkg::PH_TRAIL;
    endfunction

    // address literal: dotted octets then a closing bracket
    function void literal_step(logic [7:0] c);
      if (lit == shlc_pkg::LIT_CLOSED) begin
        lit_err = 1'b1;
      end else if (c >= shlc_pkg::CH_ZERO && c <= shlc_pkg::CH_NINE) begin
        if (digit_cnt >= shlc_pkg::OCTET_MAX) lit_err = 1'b1;
        else digit_cnt = digit_cnt + 2'd1;
      end else if (c == shlc_pkg::CH_DOT) begin
        if (digit_cnt == 2'd0 || dot_cnt >= shlc_pkg::DOTS_NEEDED) begin
          lit_err = 1'b1;
        end else begin
          dot_cnt   = dot_cnt + 2'd1;
          digit_cnt = 2'd0;
        end
      end else if (c == shlc_pkg::CH_CLOSE) begin
        if (dot_cnt != shlc_pkg::DOTS_NEEDED || digit_cnt == 2'd0) lit_err = 1'b1;
        lit = shlc_pkg::LIT_CLOSED;
      end else begin
        lit_err = 1'b1;
      end
    endfunction

    // one accepted request on the input side
    function void note_char(logic [7:0] c);
      bit            blank, is_helo, is_ehlo;
      logic [7:0]    up;
      line_verdict_t v;
      blank = (c == shlc_pkg::CH_SPACE || c == shlc_pkg::CH_TAB);
      // LF right after CR is swallowed
      if (c == shlc_pkg::CH_LF && saw_cr) begin
        saw_cr = 1'b0;
        return;
      end
      // line end: work out the verdict
      if (c == shlc_pkg::CH_CR || c == shlc_pkg::CH_LF) begin
        if (phase == shlc_pkg::PH_CMD || phase == shlc_pkg::PH_ARG_FIRST) syntax_err = 1'b1;
        else if (phase == shlc_pkg::PH_ARG) finish_argument();
        is_helo = (word_len == shlc_pkg::CMD_LEN_WORD) && helo_hit;
        is_ehlo = (word_len == shlc_pkg::CMD_LEN_WORD) && ehlo_hit;
        v.kind  = is_helo ? shlc_pkg::K_HELO :
                  (is_ehlo ? shlc_pkg::K_EHLO : shlc_pkg::K_UNKNOWN);
        if (syntax_err) v.verdict = shlc_pkg::V_SYNTAX;
        else if (is_helo) v.verdict = lit_err ? shlc_pkg::V_LITERAL : shlc_pkg::V_OK;
        else if (is_ehlo) v.verdict = shlc_pkg::V_OK;
        else v.verdict = shlc_pkg::V_SYNTAX;
        expected_q.push_back(v);
        restart_line();
        saw_cr = (c == shlc_pkg::CH_CR);
        return;
      end
      saw_cr = 1'b0;
      case (phase)
        shlc_pkg::PH_CMD: begin
          if (c == shlc_pkg::CH_SPACE) begin
            if (word_len == 3'd0) syntax_err = 1'b1;
            phase = shlc_pkg::PH_ARG_FIRST;
          end else if (c == shlc_pkg::CH_TAB) begin
            syntax_err = 1'b1;
          end else begin
            if (word_len < shlc_pkg::CMD_LEN_WORD) begin
              up = (c >= shlc_pkg::CH_LOW_A && c <= shlc_pkg::CH_LOW_Z) ? c - 8'd32 : c;
              if (up != helo_text[word_len]) helo_hit = 1'b0;
              if (up != ehlo_text[word_len]) ehlo_hit = 1'b0;
            end else begin
              helo_hit = 1'b0;
              ehlo_hit = 1'b0;
            end
            if (word_len < shlc_pkg::CMD_LEN_MAX) word_len = word_len + 3'd1;
          end
        end
        shlc_pkg::PH_ARG_FIRST: begin
          if (blank) begin
            syntax_err = 1'b1;
          end else begin
            if (c == shlc_pkg::CH_OPEN) lit = shlc_pkg::LIT_OPEN;
            phase = shlc_pkg::PH_ARG;
          end
        end
        shlc_pkg::PH_ARG: begin
          if (blank) finish_argument();
          else if (lit != shlc_pkg::LIT_NONE) literal_step(c);
        end
        default: begin
          if (!blank) syntax_err = 1'b1;
        end
      endcase
    endfunction

    function void note_failure(string msg);
      failures++;
      if (failures <= REPORT_MAX) $display("mismatch: %s", msg);
    endfunction

    // one accepted request on the output side
    function void check_verdict(logic [1:0] verdict, logic [1:0] kind);
      line_verdict_t v;
      if (expected_q.size() == 0) begin
        note_failure($sformatf("verdict %0d kind %0d with no line end pending", verdict, kind));
        return;
      end
      v = expected_q.pop_front();
      if (verdict !== v.verdict)
        note_failure($sformatf("verdict expected %0d got %0d", v.verdict, verdict));
      if (kind !== v.kind)
        note_failure($sformatf("command kind expected %0d got %0d", v.kind, kind));
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_char_in = 8'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] out_verdict;
  logic [1:0] out_command_kind;

  verdict_scoreboard book = new();
  logic [7:0]        char_stream[$];
  int unsigned       burst_left = 0;
  int unsigned       cycle_count = 0;

  smtp_helo_line_checker_top u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_char_in       (in_char_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_verdict      (out_verdict),
    .out_command_kind (out_command_kind)
  );

  // clock
  initial begin
    forever #1 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // watch both handshakes
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) book.note_char(in_char_in);
    if (rst_n && out_valid && !out_stall) book.check_verdict(out_verdict, out_command_kind);
  end

  // receiver stall pattern, with long hold-offs to back up the pipeline
  initial begin : out_side
    int unsigned rx_cycle;
    int unsigned mode_left;
    int unsigned hold_left;
    stall_mode_t mode;
    logic        stall_now;
    rx_cycle  = 0;
    mode_left = 0;
    hold_left = 0;
    mode      = RX_FREE;
    forever begin
      @(posedge clk);
      if (rst_n) begin
        rx_cycle++;
        if (rx_cycle == 300 || rx_cycle == 2500) hold_left = 400;
        if (mode_left == 0) begin
          mode      = stall_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 300);
        end
        mode_left--;
        if (hold_left != 0) begin
          stall_now = 1'b1;
          hold_left--;
        end else begin
          case (mode)
            RX_FREE:  stall_now = 1'b0;
            RX_HALF:  stall_now = 1'($urandom_range(0, 1));
            RX_LIGHT: stall_now = ($urandom_range(0, 7) == 0);
            default:  stall_now = ($urandom_range(0, 3) != 0);
          endcase
        end
        out_stall <= stall_now;
      end
    end
  end

  // command word with random letter case
  task automatic add_word(string w);
    for (int i = 0; i < w.len(); i++) begin
      if (w[i] >= "A" && w[i] <= "Z" && $urandom_range(0, 1)) char_stream.push_back(w[i] + 8'd32);
      else char_stream.push_back(w[i]);
    end
  endtask

  // bracketed address, sometimes with one flaw
  task automatic add_literal();
    lit_flaw_t   flaw;
    int unsigned n_octets, bad_octet, nd;
    flaw      = ($urandom_range(0, 2) == 0) ? lit_flaw_t'($urandom_range(1, 6)) : FLAW_NONE;
    n_octets  = (flaw == FLAW_OCTETS) ? ($urandom_range(0, 1) ? 3 : 5) : 4;
    bad_octet = $urandom_range(0, n_octets - 1);
    char_stream.push_back(shlc_pkg::CH_OPEN);
    for (int i = 0; i < n_octets; i++) begin
      if (i > 0) char_stream.push_back(shlc_pkg::CH_DOT);
      nd = $urandom_range(1, 3);
      if (flaw == FLAW_DIGITS && i == bad_octet) nd = $urandom_range(0, 1) ? 0 : 4;
      repeat (nd) char_stream.push_back(shlc_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
    end
    if (flaw == FLAW_LETTER) begin
      char_stream.push_back(shlc_pkg::CH_LOW_A + 8'($urandom_range(0, 25)));
    end
    if (flaw == FLAW_EXTRA_DOT) char_stream.push_back(shlc_pkg::CH_DOT);
    if (flaw != FLAW_NO_CLOSE) char_stream.push_back(shlc_pkg::CH_CLOSE);
    if (flaw == FLAW_AFTER_CLOSE) begin
      char_stream.push_back($urandom_range(0, 1) ? shlc_pkg::CH_CLOSE :
                            shlc_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
    end
  endtask

  // one random line: mostly well formed, some broken, some noise
  task automatic add_random_line();
    int unsigned shape, n;
    bit          helo_like;
    string       mix = "HELOhelox";
    shape = $urandom_range(0, 99);
    if (shape < 12) begin
      n = $urandom_range(0, 12);
      repeat (n) char_stream.push_back(8'($urandom_range(0, 255)));
    end else begin
      // command word
      if (shape < 80) begin
        helo_like = 1'($urandom_range(0, 1));
        add_word(helo_like ? "HELO" : "EHLO");
      end else begin
        helo_like = 1'b0;
        n = $urandom_range(0, 6);
        repeat (n) char_stream.push_back(mix[$urandom_range(0, mix.len() - 1)]);
        if ($urandom_range(0, 3) == 0) char_stream.push_back(shlc_pkg::CH_TAB);
      end
      // separator
      case ($urandom_range(0, 19))
        0:       ;
        1:       begin
          char_stream.push_back(shlc_pkg::CH_SPACE);
          char_stream.push_back(shlc_pkg::CH_SPACE);
        end
        2:       char_stream.push_back(shlc_pkg::CH_TAB);
        default: char_stream.push_back(shlc_pkg::CH_SPACE);
      endcase
      // argument
      if ($urandom_range(0, 99) < (helo_like ? 60 : 15)) begin
        add_literal();
      end else begin
        n = $urandom_range(1, 10);
        repeat (n) char_stream.push_back(8'($urandom_range(33, 255)));
      end
      // trailing blanks and the odd junk character
      n = $urandom_range(0, 3);
      repeat (n) char_stream.push_back($urandom_range(0, 1) ? shlc_pkg::CH_SPACE :
                                                             shlc_pkg::CH_TAB);
      if ($urandom_range(0, 9) == 0) char_stream.push_back(8'($urandom_range(33, 255)));
    end
    // line end
    case ($urandom_range(0, 5))
      0, 1:    begin
        char_stream.push_back(shlc_pkg::CH_CR);
        char_stream.push_back(shlc_pkg::CH_LF);
      end
      2:       char_stream.push_back(shlc_pkg::CH_CR);
      3:       char_stream.push_back(shlc_pkg::CH_LF);
      4:       begin
        char_stream.push_back(shlc_pkg::CH_LF);
        char_stream.push_back(shlc_pkg::CH_LF);
      end
      default: begin
        char_stream.push_back(shlc_pkg::CH_CR);
        char_stream.push_back(shlc_pkg::CH_CR);
      end
    endcase
  endtask

  // offer one request, in bursts with random gaps
  task automatic send_char(logic [7:0] c);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 60);
    end
    burst_left--;
    in_valid   <= 1'b1;
    in_char_in <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // main sequence
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty line with LF after CR, blanks in the wrong place,
    // junk after the argument, NUL and the top byte value
    char_stream.push_back(shlc_pkg::CH_CR);
    char_stream.push_back(shlc_pkg::CH_LF);
    char_stream.push_back(shlc_pkg::CH_TAB);
    char_stream.push_back(shlc_pkg::CH_SPACE);
    char_stream.push_back(shlc_pkg::CH_LF);
    add_word("EHLO");
    char_stream.push_back(shlc_pkg::CH_SPACE);
    char_stream.push_back(shlc_pkg::CH_SPACE);
    char_stream.push_back(shlc_pkg::CH_CR);
    add_word("helo x y");
    char_stream.push_back(shlc_pkg::CH_LF);
    char_stream.push_back(8'h00);
    char_stream.push_back(8'hFF);
    char_stream.push_back(shlc_pkg::CH_LF);

    // random lines
    while (char_stream.size() < ITEM_TARGET) add_random_line();

    foreach (char_stream[i]) send_char(char_stream[i]);
    in_valid <= 1'b0;

    // drain, then let the pipeline settle
    while (book.expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (book.failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
